/* hw/rtl/slfr_pkg.sv */
`default_nettype none

package slfr_pkg;

    localparam int BUF_DEPTH_DEF = 64;
    localparam int BYTE_W        = 8;
    localparam int IDX_W         = 6;
    localparam int POLL_W        = 17;
    localparam int TMO_W         = 16;
    localparam int BLEN_W        = 7;
    localparam int LIMIT_W       = 9;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int M_TDATA_W     = 32;

    localparam logic [BYTE_W-1:0] PRINTABLE_ABOVE = 8'd31;

    localparam logic              TEXT_MODE_RST   = 1'b1;
    localparam logic              USE_TERM_RST    = 1'b1;
    localparam logic [BYTE_W-1:0] TERM_BYTE_RST   = 8'd10;
    localparam logic [BLEN_W-1:0] BUF_LEN_RST     = 7'd64;
    localparam logic [TMO_W-1:0]  TMO_LIMIT_RST   = 16'd50000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEXT_MODE      = 3'd0,
        REG_USE_TERMINATOR = 3'd1,
        REG_TERMINATOR     = 3'd2,
        REG_BUFFER_LENGTH  = 3'd3,
        REG_TIMEOUT_LIMIT  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic              text_mode;
        logic              use_terminator;
        logic [BYTE_W-1:0] terminator_byte;
        logic [BLEN_W-1:0] buffer_length;
        logic [TMO_W-1:0]  timeout_limit;
    } cfg_t;

    typedef struct packed {
        logic              store_valid;
        logic [IDX_W-1:0]  store_index;
        logic [BYTE_W-1:0] store_data;
        logic              frame_done;
        logic              frame_good;
        logic              ended_by_terminator;
        logic              ended_by_timeout;
        logic              ended_by_overflow;
        logic [IDX_W-1:0]  frame_length;
    } result_t;

endpackage

`default_nettype wire

/* hw/rtl/slfr_cfg_regs.sv */
`default_nettype none

module slfr_cfg_regs
    import slfr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg_o
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg_o     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TEXT_MODE:      cfg_next.text_mode       = cfg_data[0];
                REG_USE_TERMINATOR: cfg_next.use_terminator  = cfg_data[0];
                REG_TERMINATOR:     cfg_next.terminator_byte = cfg_data[BYTE_W-1:0];
                REG_BUFFER_LENGTH:  cfg_next.buffer_length   = cfg_data[BLEN_W-1:0];
                REG_TIMEOUT_LIMIT:  cfg_next.timeout_limit   = cfg_data[TMO_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.text_mode       <= TEXT_MODE_RST;
            cfg_reg.use_terminator  <= USE_TERM_RST;
            cfg_reg.terminator_byte <= TERM_BYTE_RST;
            cfg_reg.buffer_length   <= BUF_LEN_RST;
            cfg_reg.timeout_limit   <= TMO_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/slfr_frame_logic.sv */
`default_nettype none

module slfr_frame_logic
    import slfr_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF,
    parameter int CNT_W     = $clog2(BUF_DEPTH)
) (
    input  wire cfg_t                cfg_i,
    input  wire logic                in_frame_i,
    input  wire logic [CNT_W-1:0]    count_i,
    input  wire logic [POLL_W-1:0]   poll_i,
    input  wire logic                mode_i,
    input  wire logic [BYTE_W-1:0]   byte_i,
    output result_t                  res_o,
    output logic                     in_frame_o,
    output logic [CNT_W-1:0]         count_o,
    output logic [POLL_W-1:0]        poll_o
);

    localparam int EXT_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam logic [LIMIT_W-1:0] DEPTH_L = LIMIT_W'(BUF_DEPTH);

    logic [LIMIT_W-1:0] cap;
    logic [LIMIT_W-1:0] limit;
    logic               active;
    logic               filter;
    logic [CNT_W-1:0]   cnt_base;
    logic [POLL_W-1:0]  poll_base;
    logic [POLL_W-1:0]  poll_inc;
    logic               room;
    logic               is_term;
    logic               keep;
    logic               sv;
    logic               term;
    logic               ovf;
    logic               tmo;
    logic               done;
    logic [CNT_W-1:0]   cnt_next;
    logic [EXT_W-1:0]   idx_ext;
    logic [EXT_W-1:0]   len_ext;

    always_comb begin
        cap   = (LIMIT_W'(cfg_i.buffer_length) > DEPTH_L) ? DEPTH_L
                                                          : LIMIT_W'(cfg_i.buffer_length);
        limit = (cap == '0) ? '0 : cap - LIMIT_W'(1);

        active    = in_frame_i | mode_i;
        filter    = cfg_i.text_mode & cfg_i.use_terminator;
        cnt_base  = in_frame_i ? count_i : '0;
        poll_base = in_frame_i ? poll_i : '0;
        poll_inc  = poll_base + POLL_W'(1);

        room    = LIMIT_W'(cnt_base) < limit;
        is_term = filter && (byte_i == cfg_i.terminator_byte);
        keep    = !filter || (byte_i > PRINTABLE_ABOVE);

        term = mode_i & room & is_term;
        sv   = mode_i & room & keep;
        ovf  = mode_i & ~room;
        tmo  = active && (poll_inc > POLL_W'(cfg_i.timeout_limit));
        done = term | tmo | ovf;

        cnt_next = cnt_base + CNT_W'(sv);
        idx_ext  = EXT_W'(cnt_base);
        len_ext  = EXT_W'(cnt_next);

        res_o.store_valid         = sv;
        res_o.store_index         = sv ? idx_ext[IDX_W-1:0] : '0;
        res_o.store_data          = sv ? byte_i : '0;
        res_o.frame_done          = done;
        res_o.frame_good          = done & ~ovf & ~(tmo & filter & ~term);
        res_o.ended_by_terminator = term;
        res_o.ended_by_timeout    = tmo;
        res_o.ended_by_overflow   = ovf;
        res_o.frame_length        = active ? len_ext[IDX_W-1:0] : '0;

        in_frame_o = active & ~done;
        count_o    = cnt_next;
        poll_o     = poll_inc;
    end

endmodule

`default_nettype wire

/* hw/rtl/serial_line_frame_receiver.sv */
// Serial line frame receiver.
// Slave stream: one transaction per poll period; s_tuser is 1 when the
// period carries a received byte in s_tdata, 0 for an empty poll.
// Master stream: one transaction per input transaction, in order, giving the
// byte to store with its buffer index, the end-of-frame causes, the frame
// status and the running length; m_tlast marks the transaction that ends a
// frame. The consumer writes the trailing zero at index frame_length.
// Config channel: cfg_index selects text_mode (0), use_terminator (1),
// terminator_byte (2), buffer_length (3), timeout_limit (4); always ready. Users
// must write it only while no transaction is in flight; the block does not enforce it.
// m_tvalid rises once the slave transaction has passed the input register, then
// the result register. Throughput: one transaction per cycle while m_tready is high,
// set by the combinational frame state update between the two registers.
// Reset: idle, both stages empty, registers at their defaults.
// Stall: with m_tready low the result register holds, the input register
// still takes one transaction, then s_tready drops until m_tready returns.
`default_nettype none

module serial_line_frame_receiver
    import slfr_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [BYTE_W-1:0]     s_tdata,   // [7:0] rx_byte
    input  wire logic                  s_tuser,   // [0] mode
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // [0] store_valid, [6:1] store_index,
                                                  // [14:7] store_data, [15] frame_good,
                                                  // [16] ended_by_terminator,
                                                  // [17] ended_by_timeout,
                                                  // [18] ended_by_overflow,
                                                  // [24:19] frame_length, [31:25] zero
    output logic                       m_tlast,   // frame_done
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(BUF_DEPTH);

    cfg_t              cfg;
    logic              in_valid_reg;
    logic              in_mode_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg;
    result_t           out_res_reg;
    result_t           out_res_next;
    logic              in_frame_reg;
    logic              in_frame_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [POLL_W-1:0] poll_reg;
    logic [POLL_W-1:0] poll_next;
    logic              advance;

    slfr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_o     (cfg)
    );

    slfr_frame_logic #(
        .BUF_DEPTH (BUF_DEPTH),
        .CNT_W     (CNT_W)
    ) u_logic (
        .cfg_i      (cfg),
        .in_frame_i (in_frame_reg),
        .count_i    (count_reg),
        .poll_i     (poll_reg),
        .mode_i     (in_mode_reg),
        .byte_i     (in_byte_reg),
        .res_o      (out_res_next),
        .in_frame_o (in_frame_next),
        .count_o    (count_next),
        .poll_o     (poll_next)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_res_reg.frame_done;
    assign m_tdata  = {7'd0,
                       out_res_reg.frame_length,
                       out_res_reg.ended_by_overflow,
                       out_res_reg.ended_by_timeout,
                       out_res_reg.ended_by_terminator,
                       out_res_reg.frame_good,
                       out_res_reg.store_data,
                       out_res_reg.store_index,
                       out_res_reg.store_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            in_frame_reg  <= 1'b0;
            count_reg     <= '0;
            poll_reg      <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                in_frame_reg  <= in_frame_next;
                count_reg     <= count_next;
                poll_reg      <= poll_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mode_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        if (advance) begin
            out_res_reg <= out_res_next;
        end
    end

`ifndef SYNTH
    a_good_needs_done: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_res_reg.frame_good |-> out_res_reg.frame_done)
        else $error("frame_good without frame_done");

    a_no_store_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_res_reg.store_valid |->
            out_res_reg.store_index == '0 && out_res_reg.store_data == '0)
        else $error("store fields set without store_valid");

    a_overflow_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_res_reg.ended_by_overflow |-> !out_res_reg.frame_good)
        else $error("overflowed frame reported good");

    a_done_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && out_res_next.frame_done |=> !in_frame_reg)
        else $error("frame still open after end");
`endif

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import slfr_pkg::*;

    localparam bit MODE_POLL = 1'b0;
    localparam bit MODE_BYTE = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_PHASES = 31;
    localparam int MAX_REPORTS   = 40;

    typedef struct packed {
        logic              has_byte;
        logic [BYTE_W-1:0] rx;
    } poll_item_t;

    typedef enum int {SINK_OPEN, SINK_COIN, SINK_MOSTLY, SINK_PATTERN} sink_style_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    wire logic             s_tready;
    logic [BYTE_W-1:0]     s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    wire logic             m_tvalid;
    logic                  m_tready  = 1'b0;
    wire logic [M_TDATA_W-1:0] m_tdata;
    wire logic             m_tlast;
    logic                  cfg_valid = 1'b0;
    wire logic             cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    poll_item_t polls_to_send[$];
    result_t    frame_results_due[$];

    cfg_t        model_cfg;
    bit          frame_open;
    int unsigned frame_bytes;
    int unsigned frame_polls;

    int failures = 0;
    int reports = 0;
    int items_sent = 0;
    int results_checked = 0;
    int settings_used = 0;
    int frames_terminated = 0;
    int frames_timed_out = 0;
    int frames_overflowed = 0;
    int bytes_stored = 0;

    int burst_left = 0;
    int gap_left = 0;
    int holds_wanted = 0;
    int holds_started = 0;
    int hold_left = 0;
    sink_style_t sink_style = SINK_OPEN;
    int sink_left = 0;
    logic [7:0] sink_pattern = 8'b1101_0010;

    serial_line_frame_receiver uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic result_t predict_frame_step(input poll_item_t item);
        result_t     r;
        int unsigned cap;
        int unsigned room;
        bit          filtering;
        bit          keep;
        r = '0;
        filtering = model_cfg.text_mode && model_cfg.use_terminator;
        if (!frame_open) begin
            if (!item.has_byte)
                return r;
            frame_open = 1'b1;
            frame_bytes = 0;
            frame_polls = 0;
        end
        cap = model_cfg.buffer_length;
        if (cap > BUF_DEPTH_DEF)
            cap = BUF_DEPTH_DEF;
        room = (cap > 0) ? cap - 1 : 0;
        if (item.has_byte) begin
            if (frame_bytes < room) begin
                keep = 1'b1;
                if (filtering) begin
                    keep = item.rx > PRINTABLE_ABOVE;
                    if (item.rx == model_cfg.terminator_byte)
                        r.ended_by_terminator = 1'b1;
                end
                if (keep) begin
                    r.store_valid = 1'b1;
                    r.store_index = frame_bytes[IDX_W-1:0];
                    r.store_data = item.rx;
                    frame_bytes++;
                end
            end else begin
                r.ended_by_overflow = 1'b1;
            end
        end
        frame_polls = (frame_polls + 1) & 32'h1FFFF;
        if (frame_polls > model_cfg.timeout_limit)
            r.ended_by_timeout = 1'b1;
        if (r.ended_by_terminator || r.ended_by_timeout || r.ended_by_overflow) begin
            r.frame_done = 1'b1;
            r.frame_good = !r.ended_by_overflow &&
                           !(r.ended_by_timeout && filtering && !r.ended_by_terminator);
            frame_open = 1'b0;
        end
        r.frame_length = frame_bytes[IDX_W-1:0];
        return r;
    endfunction

    function automatic bit field_differs(input string name, input int unsigned want_v,
                                        input int unsigned got_v);
        if (want_v == got_v)
            return 1'b0;
        reports++;
        if (reports <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
        return 1'b1;
    endfunction

    always @(posedge aclk) begin : poll_driver
        poll_item_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                item.has_byte = s_tuser;
                item.rx = s_tdata;
                frame_results_due.push_back(predict_frame_step(item));
                items_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (polls_to_send.size() != 0) begin
                    item = polls_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= item.has_byte;
                    s_tdata <= item.rx;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 32);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : holdoff_timer
        if (!aresetn) begin
            hold_left <= 0;
            holds_started <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_started != holds_wanted) begin
            hold_left <= HOLD_CYCLES;
            holds_started <= holds_started + 1;
        end
    end

    always @(posedge aclk) begin : result_sink
        bit ready_bit;
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_left = 0;
        end else begin
            if (sink_left == 0) begin
                sink_style = sink_style_t'($urandom_range(0, 3));
                sink_left = $urandom_range(20, 200);
            end else begin
                sink_left--;
            end
            case (sink_style)
                SINK_OPEN:   ready_bit = 1'b1;
                SINK_COIN:   ready_bit = 1'($urandom_range(0, 1));
                SINK_MOSTLY: ready_bit = ($urandom_range(0, 7) != 0);
                default:     ready_bit = sink_pattern[0];
            endcase
            sink_pattern = {sink_pattern[0], sink_pattern[7:1]};
            m_tready <= ready_bit && (hold_left == 0);
        end
    end

    always @(posedge aclk) begin : result_checker
        result_t want;
        result_t got;
        bit      bad;
        if (aresetn && m_tvalid && m_tready) begin
            got.store_valid = m_tdata[0];
            got.store_index = m_tdata[6:1];
            got.store_data = m_tdata[14:7];
            got.frame_good = m_tdata[15];
            got.ended_by_terminator = m_tdata[16];
            got.ended_by_timeout = m_tdata[17];
            got.ended_by_overflow = m_tdata[18];
            got.frame_length = m_tdata[24:19];
            got.frame_done = m_tlast;
            if (frame_results_due.size() == 0) begin
                failures++;
                $display("%0t: result transaction with none expected, actual tdata %h tlast %b",
                         $time, m_tdata, m_tlast);
            end else begin
                want = frame_results_due.pop_front();
                bad = 1'b0;
                bad |= field_differs("store_valid", want.store_valid, got.store_valid);
                bad |= field_differs("store_index", want.store_index, got.store_index);
                bad |= field_differs("store_data", want.store_data, got.store_data);
                bad |= field_differs("frame_done", want.frame_done, got.frame_done);
                bad |= field_differs("frame_good", want.frame_good, got.frame_good);
                bad |= field_differs("ended_by_terminator", want.ended_by_terminator,
                                     got.ended_by_terminator);
                bad |= field_differs("ended_by_timeout", want.ended_by_timeout,
                                     got.ended_by_timeout);
                bad |= field_differs("ended_by_overflow", want.ended_by_overflow,
                                     got.ended_by_overflow);
                bad |= field_differs("frame_length", want.frame_length, got.frame_length);
                bad |= field_differs("tdata padding", 0, m_tdata[31:25]);
                if (bad)
                    failures++;
                results_checked++;
                frames_terminated += got.ended_by_terminator;
                frames_timed_out += got.ended_by_timeout;
                frames_overflowed += got.ended_by_overflow;
                bytes_stored += got.store_valid;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_TEXT_MODE:      model_cfg.text_mode = value[0];
            REG_USE_TERMINATOR: model_cfg.use_terminator = value[0];
            REG_TERMINATOR:     model_cfg.terminator_byte = value[BYTE_W-1:0];
            REG_BUFFER_LENGTH:  model_cfg.buffer_length = value[BLEN_W-1:0];
            REG_TIMEOUT_LIMIT:  model_cfg.timeout_limit = value[TMO_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic apply_settings(input bit text, input bit use_term,
                                  input logic [BYTE_W-1:0] term,
                                  input logic [BLEN_W-1:0] len,
                                  input logic [TMO_W-1:0] limit);
        write_reg(REG_TEXT_MODE, CFG_DATA_W'(text));
        write_reg(REG_USE_TERMINATOR, CFG_DATA_W'(use_term));
        write_reg(REG_TERMINATOR, CFG_DATA_W'(term));
        write_reg(REG_BUFFER_LENGTH, CFG_DATA_W'(len));
        write_reg(REG_TIMEOUT_LIMIT, limit);
        settings_used++;
    endtask

    task automatic queue_poll(input bit has_byte, input logic [BYTE_W-1:0] rx);
        poll_item_t item;
        item.has_byte = has_byte;
        item.rx = rx;
        polls_to_send.push_back(item);
    endtask

    task automatic wait_idle();
        while (polls_to_send.size() != 0 || s_tvalid || frame_results_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin : stimulus
        int                phase;
        int                count;
        int                poll_pct;
        int                term_pct;
        int                pick;
        logic [BLEN_W-1:0] len;
        logic [TMO_W-1:0]  limit;
        logic [BYTE_W-1:0] term;
        logic [BYTE_W-1:0] rx;

        model_cfg.text_mode = TEXT_MODE_RST;
        model_cfg.use_terminator = USE_TERM_RST;
        model_cfg.terminator_byte = TERM_BYTE_RST;
        model_cfg.buffer_length = BUF_LEN_RST;
        model_cfg.timeout_limit = TMO_LIMIT_RST;
        frame_open = 1'b0;
        frame_bytes = 0;
        frame_polls = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: filtered text ending on newline
        queue_poll(MODE_POLL, 8'hFF);
        queue_poll(MODE_BYTE, 8'h41);
        queue_poll(MODE_BYTE, 8'h01);
        queue_poll(MODE_BYTE, 8'h1F);
        queue_poll(MODE_BYTE, 8'h20);
        queue_poll(MODE_POLL, 8'h00);
        queue_poll(MODE_BYTE, 8'hFF);
        queue_poll(MODE_BYTE, 8'h0A);
        wait_idle();

        // binary, overflow together with timeout
        apply_settings(1'b0, 1'b1, 8'h0A, 7'd2, 16'd1);
        queue_poll(MODE_BYTE, 8'h00);
        queue_poll(MODE_BYTE, 8'h0A);
        wait_idle();

        apply_settings(1'b0, 1'b0, 8'h0A, 7'd0, 16'hFFFF);
        queue_poll(MODE_BYTE, 8'h55);
        wait_idle();
        write_reg(REG_BUFFER_LENGTH, 16'd1);
        queue_poll(MODE_BYTE, 8'h80);
        wait_idle();

        // zero timeout, printable terminator, oversized buffer
        apply_settings(1'b1, 1'b1, 8'h41, 7'd127, 16'd0);
        queue_poll(MODE_BYTE, 8'h42);
        queue_poll(MODE_BYTE, 8'h41);
        queue_poll(MODE_BYTE, 8'h05);
        wait_idle();

        // text without terminator stores everything
        apply_settings(1'b1, 1'b0, 8'h41, 7'd64, 16'd3);
        queue_poll(MODE_BYTE, 8'h41);
        queue_poll(MODE_BYTE, 8'h00);
        queue_poll(MODE_POLL, 8'h41);
        queue_poll(MODE_POLL, 8'h7F);
        queue_poll(MODE_POLL, 8'h00);
        wait_idle();

        apply_settings(1'b1, 1'b1, 8'hFF, 7'd3, 16'hFFFF);
        write_reg(REG_SPARE, 16'hFFFF);
        queue_poll(MODE_BYTE, 8'hFF);
        queue_poll(MODE_BYTE, 8'h30);
        queue_poll(MODE_BYTE, 8'h31);
        queue_poll(MODE_BYTE, 8'h32);
        wait_idle();

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 9))
                0:       len = 7'd0;
                1:       len = 7'd1;
                2:       len = 7'd2;
                3:       len = 7'd64;
                4:       len = BLEN_W'($urandom_range(65, 127));
                5, 6:    len = BLEN_W'($urandom_range(2, 64));
                default: len = BLEN_W'($urandom_range(2, 16));
            endcase
            case ($urandom_range(0, 9))
                0:          limit = 16'd0;
                1:          limit = 16'hFFFF;
                2, 3, 4:    limit = TMO_W'($urandom_range(1, 20));
                5, 6, 7:    limit = TMO_W'($urandom_range(21, 200));
                default:    limit = TMO_W'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 9))
                0:          term = 8'h00;
                1:          term = 8'hFF;
                2, 3, 4:    term = 8'h0A;
                default:    term = BYTE_W'($urandom_range(0, 255));
            endcase
            apply_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           term, len, limit);
            case ($urandom_range(0, 3))
                0:       poll_pct = 0;
                1:       poll_pct = 5;
                2:       poll_pct = 25;
                default: poll_pct = 60;
            endcase
            case ($urandom_range(0, 3))
                0:       term_pct = 0;
                1:       term_pct = 3;
                2:       term_pct = 10;
                default: term_pct = 25;
            endcase
            if (phase == 4 || phase == 17)
                holds_wanted++;
            count = $urandom_range(30, 70);
            repeat (count) begin
                rx = BYTE_W'($urandom_range(0, 255));
                if ($urandom_range(0, 99) < poll_pct) begin
                    queue_poll(MODE_POLL, rx);
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < term_pct)
                        rx = model_cfg.terminator_byte;
                    else if (pick < term_pct + 10)
                        rx = BYTE_W'($urandom_range(0, PRINTABLE_ABOVE));
                    else if (pick >= term_pct + 20)
                        rx = BYTE_W'($urandom_range(PRINTABLE_ABOVE + 1, 255));
                    queue_poll(MODE_BYTE, rx);
                end
            end
            wait_idle();
        end

        $display("Checked %0d results from %0d poll periods under %0d register settings",
                 results_checked, items_sent, settings_used);
        $display("Frame ends: %0d terminator, %0d timeout, %0d overflow; %0d bytes stored",
                 frames_terminated, frames_timed_out, frames_overflowed, bytes_stored);
        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d result transactions failed", failures);
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("%0t: run timed out with %0d results outstanding", $time,
                 frame_results_due.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
